// File: hw/rtl/bda_pkg.sv
// Package: shared types and codes for the deadlock avoidance unit
package bda_pkg;
   localparam int NRES = 3;

   localparam logic [1:0] OP_REQUEST   = 2'd0;
   localparam logic [1:0] OP_RELEASE   = 2'd1;
   localparam logic [1:0] OP_SET_CLAIM = 2'd2;
   localparam logic [1:0] OP_SET_ALLOC = 2'd3;

   localparam logic [2:0] ST_DONE    = 3'd0;
   localparam logic [2:0] ST_CLAIM   = 3'd1;
   localparam logic [2:0] ST_WAIT    = 3'd2;
   localparam logic [2:0] ST_UNSAFE  = 3'd3;
   localparam logic [2:0] ST_OVERREL = 3'd4;
   localparam logic [2:0] ST_REJECT  = 3'd5;

   localparam logic [1:0] CSR_TOTAL0 = 2'd0;
   localparam logic [1:0] CSR_TOTAL1 = 2'd1;
   localparam logic [1:0] CSR_TOTAL2 = 2'd2;

   typedef struct packed {
      logic [1:0] req_type;
      logic [2:0] customer;
      logic [7:0] amount_res0;
      logic [7:0] amount_res1;
      logic [7:0] amount_res2;
   } req_type_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] avail_res0;
      logic [7:0] avail_res1;
      logic [7:0] avail_res2;
   } rsp_type;
endpackage

// File: hw/rtl/bankers_deadlock_avoidance_unit.sv
// Top level: banker's allocator with lane-parallel safety check
// Refused, release and load transactions finish without a safety check; a request runs
// one safety step per cycle, at most CUSTOMERS steps, before its response.
// Throughput: one transaction at a time; busy is high until rsp_valid.
// Each safety step retires one fitting customer chosen by the merge of all lanes.
// Reset clears totals, claims and allocations; results cannot stall.
module bankers_deadlock_avoidance_unit #(
   parameter int CUSTOMERS  = 5,
   parameter int COUNT_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  bda_pkg::req_type_type req_data,
   output logic                  rsp_valid,
   output bda_pkg::rsp_type      rsp_data,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [7:0]            csr_data
);
   import bda_pkg::*;

   localparam int CW = COUNT_BITS;
   localparam int IW = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1;
   localparam int SW = ((COUNT_BITS > 8) ? COUNT_BITS : 8) + $clog2(CUSTOMERS) + 1;
   localparam int WW = SW + 1;
   localparam logic [2:0] S_IDLE = 3'd0, S_EXEC = 3'd1, S_SAFE = 3'd2, S_FIN = 3'd3;

   logic [2:0]    state_ff, state_in;
   logic [7:0]    total_ff [NRES];
   logic [CW-1:0] claim_ff [CUSTOMERS][NRES];
   logic [CW-1:0] alloc_ff [CUSTOMERS][NRES];
   logic [SW-1:0] sum_ff [NRES];
   req_type_type  req_ff;
   logic [WW-1:0] work_ff [NRES];
   logic [CUSTOMERS-1:0] done_ff;
   logic [IW:0]   step_ff;
   logic          valid_ff, valid_in;
   logic [2:0]    status_ff;

   logic [CUSTOMERS-1:0] fits;
   logic          any;
   logic [IW-1:0] pick;
   logic [7:0]    amt [NRES];
   logic [SW-1:0] avail [NRES];
   logic [IW-1:0] cidx;
   logic          cust_ok;

   assign amt[0] = req_ff.amount_res0;
   assign amt[1] = req_ff.amount_res1;
   assign amt[2] = req_ff.amount_res2;
   assign cust_ok = ({29'd0, req_ff.customer} < 32'(CUSTOMERS));
   assign cidx = cust_ok ? IW'(req_ff.customer) : '0;

   always_comb begin
      for (int r = 0; r < NRES; r++)
         avail[r] = (SW'(total_ff[r]) > sum_ff[r]) ? SW'(total_ff[r]) - sum_ff[r] : '0;
   end

   genvar g;
   generate
      for (g = 0; g < CUSTOMERS; g++) begin : g_lane
         bda_lane #(.CW(CW), .WW(WW)) u_lane (
            .claim0(claim_ff[g][0]), .claim1(claim_ff[g][1]), .claim2(claim_ff[g][2]),
            .alloc0(alloc_ff[g][0]), .alloc1(alloc_ff[g][1]), .alloc2(alloc_ff[g][2]),
            .work0(work_ff[0]), .work1(work_ff[1]), .work2(work_ff[2]),
            .done_in(done_ff[g]), .fits(fits[g]));
      end
   endgenerate

   bda_merge #(.CUSTOMERS(CUSTOMERS), .IW(IW)) u_merge (.fits(fits), .any(any), .pick(pick));

   // checks for the current transaction
   logic bad_need, bad_avail, bad_rel, bad_claim, bad_alloc;
   logic [SW-1:0] nsum [NRES];
   always_comb begin
      bad_need = 1'b0; bad_avail = 1'b0; bad_rel = 1'b0;
      bad_claim = 1'b0; bad_alloc = 1'b0;
      for (int r = 0; r < NRES; r++) begin
         nsum[r] = sum_ff[r] - SW'(alloc_ff[cidx][r]) + SW'(amt[r]);
         if (SW'(amt[r]) + SW'(alloc_ff[cidx][r]) > SW'(claim_ff[cidx][r]) &&
             !(claim_ff[cidx][r] <= alloc_ff[cidx][r] && amt[r] == 8'd0))
            bad_need = 1'b1;
         if (SW'(amt[r]) > avail[r]) bad_avail = 1'b1;
         if (SW'(amt[r]) > SW'(alloc_ff[cidx][r])) bad_rel = 1'b1;
         if (SW'(amt[r]) > SW'({CW{1'b1}}) || amt[r] > total_ff[r] ||
             SW'(amt[r]) < SW'(alloc_ff[cidx][r]))
            bad_claim = 1'b1;
         if (SW'(amt[r]) > SW'(claim_ff[cidx][r]) || nsum[r] > SW'(total_ff[r]))
            bad_alloc = 1'b1;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (start) state_in = S_EXEC;
         S_EXEC:  state_in = (cust_ok && req_ff.req_type == OP_REQUEST && !bad_need && !bad_avail)
                             ? S_SAFE : S_IDLE;
         S_SAFE:  if (!any || step_ff == (IW+1)'(CUSTOMERS - 1)) state_in = S_FIN;
         S_FIN:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign valid_in = (state_ff == S_EXEC && state_in == S_IDLE) || (state_ff == S_FIN);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         for (int r = 0; r < NRES; r++) begin
            total_ff[r] <= '0;
            sum_ff[r] <= '0;
         end
         for (int c = 0; c < CUSTOMERS; c++)
            for (int r = 0; r < NRES; r++) begin
               claim_ff[c][r] <= '0;
               alloc_ff[c][r] <= '0;
            end
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_TOTAL0: total_ff[0] <= csr_data;
               CSR_TOTAL1: total_ff[1] <= csr_data;
               CSR_TOTAL2: total_ff[2] <= csr_data;
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: if (start) req_ff <= req_data;
            S_EXEC: begin
               if (!cust_ok) begin
                  status_ff <= ST_REJECT;
               end else begin
                  unique case (req_ff.req_type)
                     OP_REQUEST: begin
                        if (bad_need) begin
                           status_ff <= ST_CLAIM;
                        end else if (bad_avail) begin
                           status_ff <= ST_WAIT;
                        end else begin
                           for (int r = 0; r < NRES; r++) begin
                              alloc_ff[cidx][r] <= alloc_ff[cidx][r] + CW'(amt[r]);
                              sum_ff[r] <= sum_ff[r] + SW'(amt[r]);
                              work_ff[r] <= WW'(avail[r] - SW'(amt[r]));
                           end
                           done_ff <= '0;
                           step_ff <= '0;
                        end
                     end
                     OP_RELEASE: begin
                        if (bad_rel) status_ff <= ST_OVERREL;
                        else begin
                           status_ff <= ST_DONE;
                           for (int r = 0; r < NRES; r++) begin
                              alloc_ff[cidx][r] <= alloc_ff[cidx][r] - CW'(amt[r]);
                              sum_ff[r] <= sum_ff[r] - SW'(amt[r]);
                           end
                        end
                     end
                     OP_SET_CLAIM: begin
                        if (bad_claim) status_ff <= ST_REJECT;
                        else begin
                           status_ff <= ST_DONE;
                           for (int r = 0; r < NRES; r++)
                              claim_ff[cidx][r] <= CW'(amt[r]);
                        end
                     end
                     OP_SET_ALLOC: begin
                        if (bad_alloc) status_ff <= ST_REJECT;
                        else begin
                           status_ff <= ST_DONE;
                           for (int r = 0; r < NRES; r++) begin
                              alloc_ff[cidx][r] <= CW'(amt[r]);
                              sum_ff[r] <= nsum[r];
                           end
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_SAFE: begin
               step_ff <= step_ff + 1'b1;
               if (any) begin
                  done_ff[pick] <= 1'b1;
                  for (int r = 0; r < NRES; r++)
                     work_ff[r] <= work_ff[r] + WW'(alloc_ff[pick][r]);
               end
            end
            S_FIN: begin
               if (&done_ff) status_ff <= ST_DONE;
               else begin
                  status_ff <= ST_UNSAFE;
                  for (int r = 0; r < NRES; r++) begin
                     alloc_ff[cidx][r] <= alloc_ff[cidx][r] - CW'(amt[r]);
                     sum_ff[r] <= sum_ff[r] - SW'(amt[r]);
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data.status = status_ff;
   assign rsp_data.avail_res0 = avail[0][7:0];
   assign rsp_data.avail_res1 = avail[1][7:0];
   assign rsp_data.avail_res2 = avail[2][7:0];
endmodule

// File: hw/rtl/bda_lane.sv
// Lane: tests whether one customer's need fits the work vector
module bda_lane #(
   parameter int CW = 8,
   parameter int WW = 12
) (
   input  logic [CW-1:0] claim0, claim1, claim2,
   input  logic [CW-1:0] alloc0, alloc1, alloc2,
   input  logic [WW-1:0] work0, work1, work2,
   input  logic          done_in,
   output logic          fits
);
   logic [CW-1:0] n0, n1, n2;
   always_comb begin
      n0 = (claim0 > alloc0) ? claim0 - alloc0 : '0;
      n1 = (claim1 > alloc1) ? claim1 - alloc1 : '0;
      n2 = (claim2 > alloc2) ? claim2 - alloc2 : '0;
      fits = !done_in && (WW'(n0) <= work0) && (WW'(n1) <= work1) && (WW'(n2) <= work2);
   end
endmodule

// File: hw/rtl/bda_merge.sv
// Merge: picks the first fitting customer from the lane results
module bda_merge #(
   parameter int CUSTOMERS = 5,
   parameter int IW = 3
) (
   input  logic [CUSTOMERS-1:0] fits,
   output logic                 any,
   output logic [IW-1:0]        pick
);
   always_comb begin
      any = 1'b0;
      pick = '0;
      for (int i = CUSTOMERS - 1; i >= 0; i--) begin
         if (fits[i]) begin
            any = 1'b1;
            pick = IW'(i);
         end
      end
   end
endmodule

// File: hw/rtl/bda_checker.sv
// Checker: port-level properties of the deadlock avoidance unit
module bda_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input bda_pkg::rsp_type   rsp_data
);
   import bda_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted transaction without busy");
   a_rsp_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while still busy");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_REJECT) else $error("bad status code");
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double response");
endmodule

bind bankers_deadlock_avoidance_unit bda_checker u_bda_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data));

// File: verif/bankers_deadlock_avoidance_unit_tb.sv
// Testbench for the banker's deadlock avoidance unit: directed table plus random traffic
module bankers_deadlock_avoidance_unit_tb;
   import bda_pkg::*;

   localparam int NCUST = 5;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_type_type req_data;
   logic         rsp_valid;
   rsp_type      rsp_data;
   logic         csr_we;
   logic [1:0]   csr_index;
   logic [7:0]   csr_data;

   bankers_deadlock_avoidance_unit #(.CUSTOMERS(NCUST), .COUNT_BITS(8)) i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // allocator shadow state
   int unsigned total[3];
   int unsigned claim[NCUST][3];
   int unsigned held[NCUST][3];
   int unsigned held_sum[3];

   rsp_type pending_rsp[$];
   int      errors;

   typedef struct {
      req_type_type txn;
      logic         known;
      rsp_type      rsp;
   } row_type;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int unsigned free_of(int r);
      return (total[r] > held_sum[r]) ? total[r] - held_sum[r] : 0;
   endfunction

   function automatic int unsigned need_of(int c, int r);
      return (claim[c][r] > held[c][r]) ? claim[c][r] - held[c][r] : 0;
   endfunction

   function automatic bit is_safe();
      int unsigned work[3];
      bit          fin[NCUST];
      bit          fits;
      for (int r = 0; r < 3; r++) work[r] = free_of(r);
      for (int c = 0; c < NCUST; c++) fin[c] = 1'b0;
      for (int p = 0; p < NCUST; p++) begin
         for (int c = 0; c < NCUST; c++) begin
            if (!fin[c]) begin
               fits = 1'b1;
               for (int r = 0; r < 3; r++) if (need_of(c, r) > work[r]) fits = 1'b0;
               if (fits) begin
                  for (int r = 0; r < 3; r++) work[r] += held[c][r];
                  fin[c] = 1'b1;
               end
            end
         end
      end
      foreach (fin[c]) if (!fin[c]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic rsp_type allocate(req_type_type t);
      int unsigned amt[3];
      int          c;
      logic [2:0]  st;
      rsp_type     o;
      amt[0] = 32'(t.amount_res0);
      amt[1] = 32'(t.amount_res1);
      amt[2] = 32'(t.amount_res2);
      c = int'(t.customer);
      st = ST_DONE;
      if (c >= NCUST) begin
         st = ST_REJECT;
      end else begin
         case (t.req_type)
            OP_REQUEST: begin
               for (int r = 0; r < 3; r++) if (amt[r] > need_of(c, r)) st = ST_CLAIM;
               if (st == ST_DONE)
                  for (int r = 0; r < 3; r++) if (amt[r] > free_of(r)) st = ST_WAIT;
               if (st == ST_DONE) begin
                  for (int r = 0; r < 3; r++) begin
                     held[c][r] += amt[r];
                     held_sum[r] += amt[r];
                  end
                  if (!is_safe()) begin
                     st = ST_UNSAFE;
                     for (int r = 0; r < 3; r++) begin
                        held[c][r] -= amt[r];
                        held_sum[r] -= amt[r];
                     end
                  end
               end
            end
            OP_RELEASE: begin
               for (int r = 0; r < 3; r++) if (amt[r] > held[c][r]) st = ST_OVERREL;
               if (st == ST_DONE)
                  for (int r = 0; r < 3; r++) begin
                     held[c][r] -= amt[r];
                     held_sum[r] -= amt[r];
                  end
            end
            OP_SET_CLAIM: begin
               for (int r = 0; r < 3; r++)
                  if (amt[r] > 255 || amt[r] > total[r] || amt[r] < held[c][r]) st = ST_REJECT;
               if (st == ST_DONE) for (int r = 0; r < 3; r++) claim[c][r] = amt[r];
            end
            default: begin
               for (int r = 0; r < 3; r++)
                  if (amt[r] > claim[c][r] || held_sum[r] - held[c][r] + amt[r] > total[r])
                     st = ST_REJECT;
               if (st == ST_DONE)
                  for (int r = 0; r < 3; r++) begin
                     held_sum[r] = held_sum[r] - held[c][r] + amt[r];
                     held[c][r] = amt[r];
                  end
            end
         endcase
      end
      o.status = st;
      o.avail_res0 = 8'(free_of(0));
      o.avail_res1 = 8'(free_of(1));
      o.avail_res2 = 8'(free_of(2));
      return o;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
      errors++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            report("unexpected transaction", 1, 0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status)
               report("status", 32'(rsp_data.status), 32'(want.status));
            if (rsp_data.avail_res0 !== want.avail_res0)
               report("avail_res0", 32'(rsp_data.avail_res0), 32'(want.avail_res0));
            if (rsp_data.avail_res1 !== want.avail_res1)
               report("avail_res1", 32'(rsp_data.avail_res1), 32'(want.avail_res1));
            if (rsp_data.avail_res2 !== want.avail_res2)
               report("avail_res2", 32'(rsp_data.avail_res2), 32'(want.avail_res2));
         end
      end
   end

   task automatic issue(req_type_type t, logic known, rsp_type fixed);
      rsp_type p;
      start <= 1'b1;
      req_data <= t;
      @(posedge clock);
      while (busy) @(posedge clock);
      p = allocate(t);
      if (known && p !== fixed) report("table row", 32'(p), 32'(fixed));
      pending_rsp.push_back(p);
   endtask

   task automatic write_total(logic [1:0] idx, logic [7:0] v);
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      total[idx] = 32'(v);
   endtask

   function automatic req_type_type mk(logic [1:0] op, logic [2:0] c,
                                       logic [7:0] a0, logic [7:0] a1, logic [7:0] a2);
      req_type_type t;
      t.req_type = op;
      t.customer = c;
      t.amount_res0 = a0;
      t.amount_res1 = a1;
      t.amount_res2 = a2;
      return t;
   endfunction

   function automatic rsp_type rs(logic [2:0] s, logic [7:0] a0, logic [7:0] a1,
                                  logic [7:0] a2);
      rsp_type o;
      o.status = s;
      o.avail_res0 = a0;
      o.avail_res1 = a1;
      o.avail_res2 = a2;
      return o;
   endfunction

   function automatic logic [7:0] rand_amt(int lim);
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, lim));
   endfunction

   initial begin
      row_type      rows[$];
      req_type_type t;
      rsp_type      none;
      int           phase_totals[5][3];
      int           c;
      int           k;
      bit           quiet;
      errors = 0;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_TOTAL0;
      csr_data = '0;
      none = '0;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero totals straight out of reset
      rows.push_back('{mk(OP_REQUEST, 0, 0, 0, 0), 1, rs(ST_DONE, 0, 0, 0)});
      rows.push_back('{mk(OP_REQUEST, 1, 1, 0, 0), 1, rs(ST_CLAIM, 0, 0, 0)});
      rows.push_back('{mk(OP_RELEASE, 2, 0, 0, 1), 1, rs(ST_OVERREL, 0, 0, 0)});
      rows.push_back('{mk(OP_SET_CLAIM, 3, 1, 0, 0), 1, rs(ST_REJECT, 0, 0, 0)});
      rows.push_back('{mk(OP_SET_ALLOC, 4, 0, 0, 0), 1, rs(ST_DONE, 0, 0, 0)});
      rows.push_back('{mk(OP_REQUEST, 7, 0, 0, 0), 1, rs(ST_REJECT, 0, 0, 0)});
      rows.push_back('{mk(OP_SET_ALLOC, 5, 0, 0, 0), 1, rs(ST_REJECT, 0, 0, 0)});
      foreach (rows[i]) issue(rows[i].txn, rows[i].known, rows[i].rsp);
      rows.delete();

      write_total(CSR_TOTAL0, 8'd255);
      write_total(CSR_TOTAL1, 8'd255);
      write_total(CSR_TOTAL2, 8'd10);
      rows.push_back('{mk(OP_SET_CLAIM, 0, 255, 255, 10), 1, rs(ST_DONE, 255, 255, 10)});
      rows.push_back('{mk(OP_SET_CLAIM, 1, 0, 0, 11), 1, rs(ST_REJECT, 255, 255, 10)});
      rows.push_back('{mk(OP_SET_CLAIM, 1, 100, 100, 10), 1, rs(ST_DONE, 255, 255, 10)});
      rows.push_back('{mk(OP_REQUEST, 0, 255, 255, 10), 1, rs(ST_DONE, 0, 0, 0)});
      rows.push_back('{mk(OP_REQUEST, 1, 1, 0, 0), 1, rs(ST_WAIT, 0, 0, 0)});
      rows.push_back('{mk(OP_REQUEST, 1, 101, 0, 0), 1, rs(ST_CLAIM, 0, 0, 0)});
      rows.push_back('{mk(OP_RELEASE, 0, 255, 255, 10), 1, rs(ST_DONE, 255, 255, 10)});
      rows.push_back('{mk(OP_SET_ALLOC, 0, 200, 0, 5), 1, rs(ST_DONE, 55, 255, 5)});
      rows.push_back('{mk(OP_SET_ALLOC, 1, 100, 0, 0), 1, rs(ST_REJECT, 55, 255, 5)});
      rows.push_back('{mk(OP_SET_ALLOC, 1, 50, 50, 5), 1, rs(ST_DONE, 5, 205, 0)});
      rows.push_back('{mk(OP_REQUEST, 1, 5, 0, 0), 0, none});
      rows.push_back('{mk(OP_REQUEST, 0, 0, 0, 0), 0, none});
      rows.push_back('{mk(OP_SET_CLAIM, 2, 0, 0, 0), 0, none});
      rows.push_back('{mk(OP_RELEASE, 1, 50, 50, 5), 0, none});
      foreach (rows[i]) issue(rows[i].txn, rows[i].known, rows[i].rsp);
      rows.delete();

      // lower a total below the allocated sum
      write_total(CSR_TOTAL0, 8'd0);
      issue(mk(OP_RELEASE, 0, 0, 0, 0), 1, rs(ST_DONE, 0, 255, 5));
      issue(mk(OP_REQUEST, 0, 0, 0, 0), 0, none);

      phase_totals = '{'{255, 255, 255}, '{12, 9, 15}, '{0, 7, 3}, '{40, 255, 1}, '{8, 8, 8}};
      for (int ph = 0; ph < 5; ph++) begin
         write_total(CSR_TOTAL0, 8'(phase_totals[ph][0]));
         write_total(CSR_TOTAL1, 8'(phase_totals[ph][1]));
         write_total(CSR_TOTAL2, 8'(phase_totals[ph][2]));
         for (int i = 0; i < 390; i++) begin
            quiet = (ph == 2 && i < 150);
            if (!quiet && $urandom_range(0, 99) < 12) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
            k = $urandom_range(0, 99);
            c = ($urandom_range(0, 29) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
            if (k < 15) begin
               t = mk(OP_SET_CLAIM, 3'(c), rand_amt(phase_totals[ph][0]),
                      rand_amt(phase_totals[ph][1]), rand_amt(phase_totals[ph][2]));
            end else if (k < 25 && c < NCUST) begin
               t = mk(OP_SET_ALLOC, 3'(c), rand_amt(claim[c][0]), rand_amt(claim[c][1]),
                      rand_amt(claim[c][2]));
            end else if (k < 45 && c < NCUST) begin
               t = mk(OP_RELEASE, 3'(c), rand_amt(held[c][0]), rand_amt(held[c][1]),
                      rand_amt(held[c][2]));
            end else if (c < NCUST) begin
               t = mk(OP_REQUEST, 3'(c), rand_amt(need_of(c, 0)), rand_amt(need_of(c, 1)),
                      rand_amt(need_of(c, 2)));
            end else begin
               t = mk(2'($urandom_range(0, 3)), 3'(c), 8'($urandom), 8'($urandom),
                      8'($urandom));
            end
            issue(t, 1'b0, none);
         end
      end

      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
